FILE: design/pqem_pkg.sv
// Package for the extract-max priority queue: entry and command types,
// operation and status codes. No dependencies.
`default_nettype none

package pqem_pkg;

	// Operation codes carried on the operation field
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Status codes returned with every result transaction
	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_DEQUEUED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// One stored entry
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_entry;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: design/priority_queue_extract_max_unit.sv
// Top level of the extract-max priority queue. Depends on pqem_pkg, pqem_cell.
//
// Bounded priority queue kept as a chain of QUEUE_DEPTH cells sorted by
// priority, highest first; equal priorities stay in arrival order, so a
// dequeue returns the oldest of the highest-priority entries. Every input
// transaction (enqueue or dequeue) yields exactly one result transaction with
// a status: enqueued, dequeued (with value and priority), empty on dequeue or
// full on enqueue (queue unchanged, value and priority zero). One operation
// is taken per clock while in_ready is high: each cell makes one signed
// priority compare per cycle; the head cell's answer enters the result
// register in the cycle after acceptance. in_ready is low only while that
// register holds a result not yet taken. No clearing pass after reset.
`default_nettype none

module priority_queue_extract_max_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic signed [31:0] item_value,
	input  wire logic signed [15:0] item_priority,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      out_value,
	output logic signed [15:0]      out_priority,
	output logic [1:0]              status
);
	import pqem_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]           count_q;
	logic                    out_valid_q;
	logic signed [31:0]      out_value_q;
	logic signed [15:0]      out_prio_q;
	logic [1:0]              status_q;

	logic                    accept;
	logic                    is_full;
	logic                    is_empty;
	cell_cmd_t               cmd;
	entry_t                  cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]  cell_keep;
	logic [QUEUE_DEPTH-1:0]  cell_occ;

	// Handshake and command decode
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_full   = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);

	assign cmd.ins             = accept && (operation == OP_ENQUEUE) && !is_full;
	assign cmd.rem             = accept && (operation == OP_DEQUEUE) && !is_empty;
	assign cmd.new_entry.value = item_value;
	assign cmd.new_entry.prio  = item_priority;

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;

		assign cell_occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign left_e = cmd.new_entry;
			assign left_k = 1'b1;
		end else begin : g_body
			assign left_e = cell_entry[i-1];
			assign left_k = cell_keep[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_mid
			assign right_e = cell_entry[i+1];
		end

		pqem_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (cell_occ[i]),
			.left_keep  (left_k),
			.left_entry (left_e),
			.right_entry(right_e),
			.entry      (cell_entry[i]),
			.keep       (cell_keep[i])
		);
	end

	// Fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (operation == OP_ENQUEUE) begin
				out_value_q <= '0;
				out_prio_q  <= '0;
				status_q    <= is_full ? ST_FULL : ST_ENQUEUED;
			end else if (is_empty) begin
				out_value_q <= '0;
				out_prio_q  <= '0;
				status_q    <= ST_EMPTY;
			end else begin
				status_q    <= ST_DEQUEUED;
				out_value_q <= cell_entry[0].value;
				out_prio_q  <= cell_entry[0].prio;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_priority = out_prio_q;
	assign status       = status_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |=> count_q == $past(count_q) - CW'(1))
		else $error("dequeue did not lower the fill count");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted transaction produced no result");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
		else $error("head entry does not hold the highest priority");

endmodule

`default_nettype wire

FILE: design/pqem_cell.sv
// One cell of the sorted priority chain: holds one entry and decides each
// cycle whether to hold, take the new entry, or take a neighbor's entry.
// Depends on pqem_pkg.
`default_nettype none

module pqem_cell (
	input  wire logic               clk,
	input  wire pqem_pkg::cell_cmd_t cmd,
	input  wire logic               occupied,
	input  wire logic               left_keep,
	input  wire pqem_pkg::entry_t   left_entry,
	input  wire pqem_pkg::entry_t   right_entry,
	output pqem_pkg::entry_t        entry,
	output logic                    keep
);
	import pqem_pkg::*;

	entry_t entry_q;

	// Entry stays put on insert if it ranks at or above the new one
	// (ties keep the older entry ahead)
	assign keep  = occupied && (entry_q.prio >= cmd.new_entry.prio);
	assign entry = entry_q;

	// Insert shifts the lower part down by one; remove shifts all up by one
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				if (left_keep) begin
					entry_q <= cmd.new_entry;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

FILE: dv/priority_queue_extract_max_unit_tb.sv
// Self-checking testbench for priority_queue_extract_max_unit: directed and random
// enqueue/dequeue traffic, checked against a shadow copy of the queue contents.
// Depends on pqem_pkg and the RTL of the block.
module priority_queue_extract_max_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pqem_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int RANDOM_OPS  = 1800;
	localparam int HOLD_CYCLES = 120;
	localparam int MAX_REPORTS = 10;

	// One queued operation for the driver
	typedef struct {
		logic               op;
		logic signed [31:0] value;
		logic signed [15:0] prio;
		bit                 drain;
	} pq_op_t;

	// One response transaction
	typedef struct {
		logic signed [31:0] value;
		logic signed [15:0] prio;
		logic [1:0]         status;
	} pq_resp_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic signed [31:0] item_value;
	logic signed [15:0] item_priority;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out_value;
	logic signed [15:0] out_priority;
	logic [1:0]         status;

	pq_op_t   op_backlog[$];
	pq_resp_t queue_responses[$];
	pq_op_t   tx_item;
	pq_op_t   seen_item;
	pq_resp_t want;

	entry_t shadow_entries[QUEUE_DEPTH];
	int     shadow_count = 0;

	bit in_taken = 1'b0;
	bit stim_loaded = 1'b0;
	bit rx_hold;
	int launched = 0;
	int total_items = 0;
	int hold_point = 0;
	int mismatch_count = 0;

	priority_queue_extract_max_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_priority (out_priority),
		.status       (status)
	);

	// Clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Apply one operation to the shadow queue and return its response.
	// Dequeue picks the first strictly larger priority, so ties go to the oldest.
	function automatic pq_resp_t serve_operation(input pq_op_t cmd);
		pq_resp_t r;
		int best;
		r.value  = '0;
		r.prio   = '0;
		r.status = ST_ENQUEUED;
		if (cmd.op == OP_ENQUEUE) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_entries[shadow_count].value = cmd.value;
				shadow_entries[shadow_count].prio  = cmd.prio;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			best = 0;
			for (int i = 1; i < shadow_count; i++) begin
				if ($signed(shadow_entries[i].prio) > $signed(shadow_entries[best].prio))
					best = i;
			end
			r.value  = shadow_entries[best].value;
			r.prio   = shadow_entries[best].prio;
			r.status = ST_DEQUEUED;
			// close the gap, keep arrival order
			for (int i = best; i < shadow_count - 1; i++)
				shadow_entries[i] = shadow_entries[i + 1];
			shadow_count--;
		end
		return r;
	endfunction

	// Idle share in percent for each side, by traffic phase
	function automatic int idle_share(input bit rx_side);
		int phase;
		phase = (launched * 3) / total_items;
		case (phase)
			0: return rx_side ? 76 : 29;
			1: return rx_side ? 29 : 76;
			default: return 0;
		endcase
	endfunction

	task automatic push_op(input logic op, input logic [31:0] v, input logic [15:0] p,
			input bit drain);
		pq_op_t t;
		t.op    = op;
		t.value = v;
		t.prio  = p;
		t.drain = drain;
		op_backlog.push_back(t);
	endtask

	// Input driver: new transaction at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (arst_n === 1'b1 && stim_loaded) begin
			if (in_valid && !in_taken) begin
				// hold until accepted
			end else if (op_backlog.size() == 0 ||
					(op_backlog[0].drain && queue_responses.size() != 0) ||
					($urandom_range(0, 99) < idle_share(1'b0))) begin
				in_valid <= 1'b0;
			end else begin
				tx_item = op_backlog.pop_front();
				in_valid      <= 1'b1;
				operation     <= tx_item.op;
				item_value    <= tx_item.value;
				item_priority <= tx_item.prio;
				launched++;
			end
		end
	end

	// Output side ready, with random stalls and one long hold-off
	always @(negedge clk) begin
		if (arst_n === 1'b1 && stim_loaded)
			out_ready <= !rx_hold && ($urandom_range(0, 99) >= idle_share(1'b1));
	end

	// Long receiver hold-off while the sender keeps offering
	initial begin
		rx_hold = 1'b0;
		while (!(stim_loaded && launched >= hold_point && hold_point > 0))
			@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Monitor: record accepted operations, check each accepted response
	always @(posedge clk) begin
		if (arst_n !== 1'b1) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				seen_item.op    = operation;
				seen_item.value = item_value;
				seen_item.prio  = item_priority;
				seen_item.drain = 1'b0;
				queue_responses.push_back(serve_operation(seen_item));
			end
			if (out_valid && out_ready) begin
				if (queue_responses.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: response with no pending operation: %s %0d %0d %0d",
							$realtime, "value/prio/st", out_value, out_priority,
							status);
				end else begin
					want = queue_responses.pop_front();
					if (out_value !== want.value || out_priority !== want.prio ||
							status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display({"%0t: mismatch: exp value %0d prio %0d st %0d,",
								" got value %0d prio %0d st %0d"},
								$realtime, want.value, want.prio, want.status,
								out_value, out_priority, status);
					end
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int burst_len;
		int enq_pct;
		int prio_style;
		logic op;
		logic [15:0] p;
		bit drain;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_ENQUEUE;
		item_value    = '0;
		item_priority = '0;
		out_ready     = 1'b0;

		// Directed: dequeue when empty, extremes, equal-priority order
		push_op(OP_DEQUEUE, 32'h0, 16'h0, 1'b0);
		push_op(OP_ENQUEUE, 32'h7fffffff, 16'h8000, 1'b0);
		push_op(OP_ENQUEUE, 32'h80000000, 16'h7fff, 1'b0);
		push_op(OP_ENQUEUE, 32'h00000000, 16'h7fff, 1'b0);
		push_op(OP_DEQUEUE, 32'hffffffff, 16'hffff, 1'b0);
		push_op(OP_DEQUEUE, 32'h0, 16'h0, 1'b0);
		push_op(OP_DEQUEUE, 32'h0, 16'h0, 1'b0);
		push_op(OP_DEQUEUE, 32'h0, 16'h0, 1'b0);
		// Fill to capacity, then one enqueue when full
		for (int i = 0; i < QUEUE_DEPTH; i++)
			push_op(OP_ENQUEUE, $urandom(), 16'($urandom_range(0, 7) - 4), 1'b0);
		push_op(OP_ENQUEUE, 32'hffffffff, 16'h7fff, 1'b0);

		// Random bursts: fill-heavy, drain-heavy or balanced
		while (op_backlog.size() < 25 + RANDOM_OPS) begin
			burst_len  = $urandom_range(4, 40);
			prio_style = $urandom_range(0, 3);
			case ($urandom_range(0, 2))
				0: enq_pct = 80;
				1: enq_pct = 25;
				default: enq_pct = 50;
			endcase
			for (int k = 0; k < burst_len; k++) begin
				op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
				case (prio_style)
					1: p = 16'($urandom_range(0, 4) - 2);  // many ties
					2: begin
						case ($urandom_range(0, 3))
							0: p = 16'h8000;
							1: p = 16'h7fff;
							2: p = 16'h0000;
							default: p = 16'hffff;
						endcase
					end
					default: p = 16'($urandom());
				endcase
				// sender waits for all responses before these
				drain = (op_backlog.size() == 700) || (op_backlog.size() == 1500);
				push_op(op, $urandom(), p, drain);
			end
		end
		total_items = op_backlog.size();
		hold_point  = (total_items * 7) / 8;
		stim_loaded = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (queue_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		mismatch_count += queue_responses.size();

		if (mismatch_count == 0)
			$display("priority_queue_extract_max_unit_tb: clean");
		else
			$display("priority_queue_extract_max_unit_tb: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("priority_queue_extract_max_unit_tb: errors");
		$finish;
	end

endmodule

FILE: files.f
design/pqem_pkg.sv
design/pqem_cell.sv
design/priority_queue_extract_max_unit.sv
dv/priority_queue_extract_max_unit_tb.sv
